[hw/rtl/ioq_pkg.sv]
// Package for the in-order response queue: field widths, operation and
// status codes, slot states, and the records passed between the modules.
// No dependencies.
`timescale 1ns / 1ps

package ioq_pkg;

	localparam int OP_W     = 3;
	localparam int SLOT_W   = 4;
	localparam int STAMP_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int MASK_W   = 32;
	localparam int LANE_W   = 5;
	localparam int WIDX_W   = 1;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 3;
	localparam int SIZE_W   = 5;

	typedef enum logic [OP_W-1:0] {
		OP_RESERVE  = 3'd0,
		OP_SET_PEND = 3'd1,
		OP_QUERY    = 3'd2,
		OP_MARK     = 3'd3,
		OP_CONSUME  = 3'd4,
		OP_WRITE    = 3'd5,
		OP_READ     = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 3'd0,
		STS_FULL       = 3'd1,
		STS_NOT_READY  = 3'd2,
		STS_STALE      = 3'd3,
		STS_NO_PENDING = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE  = 2'd0,
		SLOT_WAIT  = 2'd1,
		SLOT_READY = 2'd2
	} slot_state_t;

	typedef struct packed {
		slot_state_t          state;
		logic [STAMP_W-1:0]   stamp;
		logic [COUNT_W-1:0]   waiting;
		logic [MASK_W-1:0]    lanes;
	} entry_t;

	localparam entry_t ENTRY_FREE = '{state: SLOT_FREE, stamp: '0, waiting: '0, lanes: '0};

	typedef struct packed {
		op_t                  opcode;
		logic [SLOT_W-1:0]    token_slot;
		logic [STAMP_W-1:0]   token_stamp;
		logic [COUNT_W-1:0]   response_count;
		logic [MASK_W-1:0]    lane_mask;
		logic [LANE_W-1:0]    lane;
		logic [WIDX_W-1:0]    word_index;
		logic [DATA_W-1:0]    write_value;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_W-1:0]    given_slot;
		logic [STAMP_W-1:0]   given_stamp;
		logic                 became_ready;
		logic                 has_pending;
		logic [DATA_W-1:0]    read_value;
		logic                 head_is_ready;
		logic [SIZE_W-1:0]    fill_level;
		logic [SIZE_W-1:0]    ready_total;
		logic [SIZE_W-1:0]    waiting_total;
		logic [MASK_W-1:0]    head_lanes;
	} result_t;

endpackage

[hw/rtl/in_order_response_queue_top.sv]
// Top level of the in-order response queue: handshakes, operation sequencer,
// pointers and counters, result register.
// Depends on ioq_pkg, ioq_entry_store and ioq_payload_store.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   reserve, set pending, query, mark response, consume head, write lane or
//   read head lane. Output channel (out_valid/out_ready) returns exactly one
//   result transaction per input, in order, with the queue status after it.
//   cfg_write_en/cfg_write_data set the ring size (clamped to 1..ENTRIES) and
//   empty the ring; write it only while no transaction is in flight.
// Sequencing
//   Each operation runs in order: read the entry and payload memories,
//   modify and write back, re-read the head entry, load the result register.
//   The single read port of the entry memory needs the separate head re-read,
//   and no new transaction is taken until the result register is loaded.
//   A new transaction is taken while the previous result still waits.
// Reset and stall
//   Reset frees every entry through per-entry valid flags (no clearing pass),
//   sets the size to min(16, ENTRIES) and the next stamp to one.
//   When the receiver stalls, the finished result is held in the sequencer
//   until the result register drains; no input is taken meanwhile.
module in_order_response_queue_top import ioq_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int LANES   = 32,
	parameter int WORDS   = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [SIZE_W-1:0]    cfg_write_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [SLOT_W-1:0]    token_slot,
	input  logic [STAMP_W-1:0]   token_stamp,
	input  logic [COUNT_W-1:0]   response_count,
	input  logic [MASK_W-1:0]    lane_mask,
	input  logic [LANE_W-1:0]    lane,
	input  logic [WIDX_W-1:0]    word_index,
	input  logic [DATA_W-1:0]    write_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    given_slot,
	output logic [STAMP_W-1:0]   given_stamp,
	output logic                 became_ready,
	output logic                 has_pending,
	output logic [DATA_W-1:0]    read_value,
	output logic                 head_is_ready,
	output logic [SIZE_W-1:0]    fill_level,
	output logic [SIZE_W-1:0]    ready_total,
	output logic [SIZE_W-1:0]    waiting_total,
	output logic [MASK_W-1:0]    head_lanes
);

	localparam int PER = LANES * WORDS;
	localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW  = (PER > 1) ? $clog2(PER) : 1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'((ENTRIES < 16) ? ENTRIES : 16);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_HEAD = 4'b0100,
		S_DONE = 4'b1000
	} seq_state_t;

	seq_state_t         state_q;
	item_t              item_q;
	result_t            res_q;
	result_t            out_q;
	logic               out_valid_q;

	logic [SIZE_W-1:0]  qsize_q;
	logic [SW-1:0]      head_q;
	logic [SW-1:0]      tail_q;
	logic [SIZE_W-1:0]  occ_q;
	logic [SIZE_W-1:0]  ready_q;
	logic [SIZE_W-1:0]  wait_q;
	logic [STAMP_W-1:0] stamp_q;

	logic               accept;
	op_t                op_in;
	logic               ent_rd_en;
	logic [SW-1:0]      ent_rd_addr;
	entry_t             ent;
	logic               ent_wr_en;
	logic [SW-1:0]      ent_wr_addr;
	entry_t             ent_wr;

	logic [SW-1:0]      pay_rd_row;
	logic [PW-1:0]      pay_rd_pos;
	logic [DATA_W-1:0]  pay_word;
	logic [PER-1:0]     pay_bits;
	logic               pay_wr_en;
	logic               row_clr_en;
	logic [SW-1:0]      row_clr;

	// modify stage
	logic [SW-1:0]      slot;
	logic               tok_ok;
	logic               hd_rdy;
	logic               in_range;
	logic [PW-1:0]      pos;
	logic               mv_en;
	slot_state_t        mv_to;
	status_t            sts;
	logic               became;
	logic               pend;
	logic [DATA_W-1:0]  rd_val;
	logic               gv;
	logic [SW-1:0]      head_n;
	logic [SW-1:0]      tail_n;
	logic [SIZE_W-1:0]  occ_n;
	logic [SIZE_W-1:0]  ready_n;
	logic [SIZE_W-1:0]  wait_n;
	logic [STAMP_W-1:0] stamp_n;
	logic               load_out;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			clamp_size = SIZE_W'(1);
		end else if (32'(v) > ENTRIES) begin
			clamp_size = SIZE_W'(ENTRIES);
		end else begin
			clamp_size = v;
		end
	endfunction

	// advance a ring pointer, wrapping at the size in use
	function automatic logic [SW-1:0] advance(input logic [SW-1:0] p,
	                                          input logic [SIZE_W-1:0] size);
		if (32'(p) + 1 == 32'(size)) begin
			advance = '0;
		end else begin
			advance = SW'(32'(p) + 1);
		end
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign op_in    = op_t'(opcode);

	// Read port: the operation's entry on acceptance, the new head afterwards.
	assign ent_rd_en = accept || (state_q == S_HEAD);
	always_comb begin
		if (state_q == S_HEAD) begin
			ent_rd_addr = head_q;
		end else if (op_in == OP_RESERVE) begin
			ent_rd_addr = tail_q;
		end else if (op_in == OP_CONSUME || op_in == OP_READ) begin
			ent_rd_addr = head_q;
		end else begin
			ent_rd_addr = SW'(token_slot);
		end
	end

	assign pay_rd_row = (op_in == OP_WRITE) ? SW'(token_slot) : head_q;
	assign pay_rd_pos = PW'(32'(lane) * WORDS + 32'(word_index));

	ioq_entry_store #(
		.ENTRIES (ENTRIES)
	) u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_all (cfg_write_en),
		.rd_en     (ent_rd_en),
		.rd_addr   (ent_rd_addr),
		.rd_data   (ent),
		.wr_en     (ent_wr_en),
		.wr_addr   (ent_wr_addr),
		.wr_data   (ent_wr)
	);

	ioq_payload_store #(
		.ENTRIES (ENTRIES),
		.LANES   (LANES),
		.WORDS   (WORDS)
	) u_payload (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_all (cfg_write_en),
		.clear_en  (row_clr_en),
		.clear_row (row_clr),
		.rd_en     (accept),
		.rd_row    (pay_rd_row),
		.rd_pos    (pay_rd_pos),
		.rd_word   (pay_word),
		.rd_bits   (pay_bits),
		.wr_en     (pay_wr_en),
		.wr_row    (slot),
		.wr_pos    (pos),
		.wr_word   (item_q.write_value),
		.wr_bits   (pay_bits | (PER'(1) << pos))
	);

	// Modify: decide the operation from the entry just read, write it back.
	always_comb begin
		slot     = SW'(item_q.token_slot);
		tok_ok   = (32'(item_q.token_slot) < 32'(qsize_q)) && (ent.state != SLOT_FREE)
		           && (ent.stamp == item_q.token_stamp);
		hd_rdy   = (occ_q != '0) && (ent.state == SLOT_READY);
		in_range = (32'(item_q.lane) < LANES) && (32'(item_q.word_index) < WORDS);
		pos      = in_range ? PW'(32'(item_q.lane) * WORDS + 32'(item_q.word_index)) : '0;

		sts        = STS_OK;
		became     = 1'b0;
		pend       = 1'b0;
		rd_val     = '0;
		gv         = 1'b0;
		mv_en      = 1'b0;
		mv_to      = SLOT_FREE;
		ent_wr_en  = 1'b0;
		ent_wr_addr = slot;
		ent_wr     = ent;
		pay_wr_en  = 1'b0;
		row_clr_en = 1'b0;
		row_clr    = head_q;
		head_n     = head_q;
		tail_n     = tail_q;
		occ_n      = occ_q;
		stamp_n    = stamp_q;

		unique case (item_q.opcode)
			OP_RESERVE: begin
				if (32'(occ_q) >= 32'(qsize_q) || ent.state != SLOT_FREE) begin
					sts = STS_FULL;
				end else begin
					gv          = 1'b1;
					mv_en       = 1'b1;
					mv_to       = (item_q.response_count == '0) ? SLOT_READY : SLOT_WAIT;
					ent_wr_en   = 1'b1;
					ent_wr_addr = tail_q;
					ent_wr      = '{state: mv_to, stamp: stamp_q,
					                waiting: item_q.response_count, lanes: item_q.lane_mask};
					row_clr_en  = 1'b1;
					row_clr     = tail_q;
					tail_n      = advance(tail_q, qsize_q);
					occ_n       = occ_q + SIZE_W'(1);
					stamp_n     = stamp_q + STAMP_W'(1);
				end
			end
			OP_SET_PEND: begin
				if (!tok_ok) begin
					sts = STS_STALE;
				end else begin
					mv_en          = 1'b1;
					mv_to          = (item_q.response_count == '0) ? SLOT_READY : SLOT_WAIT;
					ent_wr_en      = 1'b1;
					ent_wr.state   = mv_to;
					ent_wr.waiting = item_q.response_count;
				end
			end
			OP_QUERY: begin
				if (!tok_ok) begin
					sts = STS_STALE;
				end else begin
					pend = (ent.waiting != '0);
				end
			end
			OP_MARK: begin
				if (!tok_ok) begin
					sts = STS_STALE;
				end else if (ent.waiting == '0) begin
					sts = STS_NO_PENDING;
				end else begin
					ent_wr_en      = 1'b1;
					ent_wr.waiting = ent.waiting - COUNT_W'(1);
					if (ent.waiting == COUNT_W'(1)) begin
						mv_en        = 1'b1;
						mv_to        = SLOT_READY;
						ent_wr.state = SLOT_READY;
						became       = 1'b1;
					end
				end
			end
			OP_CONSUME: begin
				if (!hd_rdy) begin
					sts = STS_NOT_READY;
				end else begin
					mv_en          = 1'b1;
					mv_to          = SLOT_FREE;
					ent_wr_en      = 1'b1;
					ent_wr_addr    = head_q;
					ent_wr.state   = SLOT_FREE;
					ent_wr.waiting = '0;
					ent_wr.lanes   = '0;
					row_clr_en     = 1'b1;
					head_n         = advance(head_q, qsize_q);
					occ_n          = occ_q - SIZE_W'(1);
				end
			end
			OP_WRITE: begin
				if (!tok_ok) begin
					sts = STS_STALE;
				end else begin
					// out-of-range lane or word: ignored, still ok
					pay_wr_en = in_range;
				end
			end
			OP_READ: begin
				if (!hd_rdy) begin
					sts = STS_NOT_READY;
				end else if (in_range && pay_bits[pos]) begin
					rd_val = pay_word;
				end
			end
			OP_NOP: begin
			end
		endcase

		// state-move bookkeeping of the ready and waiting counters
		ready_n = ready_q;
		wait_n  = wait_q;
		if (mv_en) begin
			ready_n = ready_q - SIZE_W'(ent.state == SLOT_READY) + SIZE_W'(mv_to == SLOT_READY);
			wait_n  = wait_q - SIZE_W'(ent.state == SLOT_WAIT) + SIZE_W'(mv_to == SLOT_WAIT);
		end

		// only the modify step may write memories
		if (state_q != S_LOOK) begin
			ent_wr_en  = 1'b0;
			pay_wr_en  = 1'b0;
			row_clr_en = 1'b0;
		end
	end

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			qsize_q     <= SIZE_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			ready_q     <= '0;
			wait_q      <= '0;
			stamp_q     <= STAMP_W'(1);
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_LOOK;
				S_LOOK: state_q <= S_HEAD;
				S_HEAD: state_q <= S_DONE;
				S_DONE: if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// a size write empties the ring; the stamp sequence keeps going
			if (cfg_write_en) begin
				qsize_q <= clamp_size(cfg_write_data);
				head_q  <= '0;
				tail_q  <= '0;
				occ_q   <= '0;
				ready_q <= '0;
				wait_q  <= '0;
			end else if (state_q == S_LOOK) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				occ_q   <= occ_n;
				ready_q <= ready_n;
				wait_q  <= wait_n;
				stamp_q <= stamp_n;
			end
		end
	end

	// item, per-operation result and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{opcode: op_in, token_slot: token_slot, token_stamp: token_stamp,
			            response_count: response_count, lane_mask: lane_mask, lane: lane,
			            word_index: word_index, write_value: write_value};
		end
		if (state_q == S_LOOK) begin
			res_q <= '{status: sts, given_slot: gv ? SLOT_W'(tail_q) : '0,
			           given_stamp: gv ? stamp_q : '0, became_ready: became,
			           has_pending: pend, read_value: rd_val, head_is_ready: 1'b0,
			           fill_level: '0, ready_total: '0, waiting_total: '0,
			           head_lanes: '0};
		end
		if (load_out) begin
			out_q <= '{status: res_q.status, given_slot: res_q.given_slot,
			           given_stamp: res_q.given_stamp, became_ready: res_q.became_ready,
			           has_pending: res_q.has_pending, read_value: res_q.read_value,
			           head_is_ready: (occ_q != '0) && (ent.state == SLOT_READY),
			           fill_level: occ_q, ready_total: ready_q, waiting_total: wait_q,
			           head_lanes: (occ_q != '0) ? ent.lanes : '0};
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign given_slot    = out_q.given_slot;
	assign given_stamp   = out_q.given_stamp;
	assign became_ready  = out_q.became_ready;
	assign has_pending   = out_q.has_pending;
	assign read_value    = out_q.read_value;
	assign head_is_ready = out_q.head_is_ready;
	assign fill_level    = out_q.fill_level;
	assign ready_total   = out_q.ready_total;
	assign waiting_total = out_q.waiting_total;
	assign head_lanes    = out_q.head_lanes;

	// every occupied entry is either ready or waiting
	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(6'(ready_q) + 6'(wait_q)) == 6'(occ_q))
		else $error("ready and waiting counts do not add up to the fill level");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(qsize_q))
		else $error("fill level exceeds ring size");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result presented without a finished operation");

	a_pointers_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) < 32'(qsize_q)) && (32'(tail_q) < 32'(qsize_q)))
		else $error("ring pointer beyond ring size");

endmodule

[hw/rtl/ioq_entry_store.sv]
// Entry memory of the in-order response queue: state, stamp, pending count
// and lane mask per slot, one read and one write port, registered read.
// Depends on ioq_pkg.
`timescale 1ns / 1ps

module ioq_entry_store import ioq_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear_all,
	input  logic                     rd_en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	output entry_t                   rd_data,
	input  logic                     wr_en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
	input  entry_t                   wr_data
);

	entry_t               mem [ENTRIES];
	entry_t               rd_q;
	logic [ENTRIES-1:0]   vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// entries never written since reset or a size change read as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clear_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : ENTRY_FREE;

endmodule

[hw/rtl/ioq_payload_store.sv]
// Payload memory and per-entry written-bit rows of the in-order response
// queue, with a valid flag per row so a row reads as all unwritten when cleared.
// Depends on ioq_pkg.
`timescale 1ns / 1ps

module ioq_payload_store import ioq_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int LANES   = 32,
	parameter int WORDS   = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear_all,
	input  logic                           clear_en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] clear_row,
	input  logic                           rd_en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_row,
	input  logic [((LANES * WORDS > 1) ? $clog2(LANES * WORDS) : 1)-1:0] rd_pos,
	output logic [DATA_W-1:0]              rd_word,
	output logic [LANES*WORDS-1:0]         rd_bits,
	input  logic                           wr_en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_row,
	input  logic [((LANES * WORDS > 1) ? $clog2(LANES * WORDS) : 1)-1:0] wr_pos,
	input  logic [DATA_W-1:0]              wr_word,
	input  logic [LANES*WORDS-1:0]         wr_bits
);

	localparam int PER = LANES * WORDS;
	localparam int RW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW  = (PER > 1) ? $clog2(PER) : 1;
	localparam int AW  = (ENTRIES * PER > 1) ? $clog2(ENTRIES * PER) : 1;

	logic [DATA_W-1:0]   word_mem [ENTRIES*PER];
	logic [PER-1:0]      bits_mem [ENTRIES];
	logic [DATA_W-1:0]   word_q;
	logic [PER-1:0]      bits_q;
	logic [ENTRIES-1:0]  row_vld_q;
	logic                row_vld_rd_q;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;

	function automatic logic [AW-1:0] word_addr(input logic [RW-1:0] row,
	                                            input logic [PW-1:0] pos);
		word_addr = AW'(32'(row) * PER + 32'(pos));
	endfunction

	assign rd_addr = word_addr(rd_row, rd_pos);
	assign wr_addr = word_addr(wr_row, wr_pos);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_mem[wr_addr] <= wr_word;
			bits_mem[wr_row]  <= wr_bits;
		end
		if (rd_en) begin
			word_q <= word_mem[rd_addr];
			bits_q <= bits_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			row_vld_rd_q <= 1'b0;
		end else begin
			if (clear_all) begin
				row_vld_q <= '0;
			end else if (clear_en) begin
				row_vld_q[clear_row] <= 1'b0;
			end else if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				row_vld_rd_q <= row_vld_q[rd_row];
			end
		end
	end

	assign rd_word = word_q;
	assign rd_bits = row_vld_rd_q ? bits_q : '0;

endmodule

[test/in_order_response_queue_top_tb.sv]
// Self-checking testbench for the in-order response queue top level.
// Depends on ioq_pkg and the in_order_response_queue_top RTL; needs no files.
`timescale 1ns / 1ps

module in_order_response_queue_top_tb;
	import ioq_pkg::*;

	localparam int RING_MAX    = 16;
	localparam int SLOT_WORDS  = 64;        // lanes * words held per entry
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 160;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Block inputs, all known from time zero
	logic                cfg_write_en   = 1'b0;
	logic [SIZE_W-1:0]   cfg_write_data = '0;
	logic                in_valid       = 1'b0;
	logic [OP_W-1:0]     opcode         = '0;
	logic [SLOT_W-1:0]   token_slot     = '0;
	logic [STAMP_W-1:0]  token_stamp    = '0;
	logic [COUNT_W-1:0]  response_count = '0;
	logic [MASK_W-1:0]   lane_mask      = '0;
	logic [LANE_W-1:0]   lane           = '0;
	logic [WIDX_W-1:0]   word_index     = '0;
	logic [DATA_W-1:0]   write_value    = '0;
	logic                out_ready      = 1'b0;

	// Block outputs
	logic                in_ready;
	logic                out_valid;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   given_slot;
	logic [STAMP_W-1:0]  given_stamp;
	logic                became_ready;
	logic                has_pending;
	logic [DATA_W-1:0]   read_value;
	logic                head_is_ready;
	logic [SIZE_W-1:0]   fill_level;
	logic [SIZE_W-1:0]   ready_total;
	logic [SIZE_W-1:0]   waiting_total;
	logic [MASK_W-1:0]   head_lanes;

	in_order_response_queue_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.token_slot    (token_slot),
		.token_stamp   (token_stamp),
		.response_count(response_count),
		.lane_mask     (lane_mask),
		.lane          (lane),
		.word_index    (word_index),
		.write_value   (write_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.given_slot    (given_slot),
		.given_stamp   (given_stamp),
		.became_ready  (became_ready),
		.has_pending   (has_pending),
		.read_value    (read_value),
		.head_is_ready (head_is_ready),
		.fill_level    (fill_level),
		.ready_total   (ready_total),
		.waiting_total (waiting_total),
		.head_lanes    (head_lanes)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the queue: ring entries, payload, pointers, counters.
	// ------------------------------------------------------------------
	slot_state_t   ring_state [RING_MAX];
	logic [31:0]   ring_stamp [RING_MAX];
	logic [7:0]    ring_wait  [RING_MAX];
	logic [31:0]   ring_lanes [RING_MAX];
	logic [63:0]   word_written [RING_MAX];
	// Payload words ever stored since reset; the payload memory is not
	// cleared, so reads are steered only to addresses that hold a value.
	logic [63:0]   ever_stored [RING_MAX];
	logic [63:0]   payload_mem [RING_MAX*SLOT_WORDS];
	int            rd_ptr;
	int            wr_ptr;
	int            fill;
	int            ready_cnt;
	int            wait_cnt;
	int            ring_size;
	logic [31:0]   stamp_next;

	result_t       awaited_results [$];
	int            failures = 0;
	int unsigned   cycle_count = 0;

	// Sender and receiver pacing
	bit            gaps_on = 1'b1;
	int            burst_left = 0;
	int            hold_req = 0;
	int            hold_len = 0;
	int            hold_seen = 0;
	int            hold_left = 0;
	int            rx_mode = 0;
	int            rx_mode_left = 0;

	task automatic clear_ring();
		for (int i = 0; i < RING_MAX; i++) begin
			ring_state[i]   = SLOT_FREE;
			ring_stamp[i]   = '0;
			ring_wait[i]    = '0;
			ring_lanes[i]   = '0;
			word_written[i] = '0;
		end
		rd_ptr    = 0;
		wr_ptr    = 0;
		fill      = 0;
		ready_cnt = 0;
		wait_cnt  = 0;
	endtask

	// Move an entry to a new state and keep the ready/waiting totals in step.
	task automatic retag(int s, slot_state_t to);
		if (ring_state[s] == SLOT_WAIT) wait_cnt--;
		if (ring_state[s] == SLOT_READY) ready_cnt--;
		if (to == SLOT_WAIT) wait_cnt++;
		if (to == SLOT_READY) ready_cnt++;
		ring_state[s] = to;
	endtask

	function automatic bit token_valid(logic [3:0] s, logic [31:0] t);
		return (int'(s) < ring_size) && (ring_state[s] != SLOT_FREE) && (ring_stamp[s] == t);
	endfunction

	function automatic bit head_live();
		return (fill != 0) && (ring_state[rd_ptr] == SLOT_READY);
	endfunction

	// Apply one operation to the shadow queue and return the expected result.
	task automatic predict_queue_op(input item_t it, output result_t r);
		int         s;
		logic [5:0] pos;
		s   = int'(it.token_slot);
		pos = {it.lane, it.word_index};
		r   = '0;
		r.status = STS_OK;
		case (it.opcode)
			OP_RESERVE: begin
				if (fill >= ring_size || ring_state[wr_ptr] != SLOT_FREE) begin
					r.status = STS_FULL;
				end else begin
					r.given_slot       = wr_ptr[3:0];
					r.given_stamp      = stamp_next;
					ring_stamp[wr_ptr] = stamp_next;
					stamp_next         = stamp_next + 32'd1;
					ring_wait[wr_ptr]  = it.response_count;
					ring_lanes[wr_ptr] = it.lane_mask;
					word_written[wr_ptr] = '0;
					retag(wr_ptr, (it.response_count == 0) ? SLOT_READY : SLOT_WAIT);
					wr_ptr = (wr_ptr + 1) % ring_size;
					fill++;
				end
			end
			OP_SET_PEND: begin
				if (!token_valid(it.token_slot, it.token_stamp)) begin
					r.status = STS_STALE;
				end else begin
					ring_wait[s] = it.response_count;
					retag(s, (it.response_count == 0) ? SLOT_READY : SLOT_WAIT);
				end
			end
			OP_QUERY: begin
				if (!token_valid(it.token_slot, it.token_stamp)) r.status = STS_STALE;
				else r.has_pending = (ring_wait[s] != 0);
			end
			OP_MARK: begin
				if (!token_valid(it.token_slot, it.token_stamp)) begin
					r.status = STS_STALE;
				end else if (ring_wait[s] == 0) begin
					r.status = STS_NO_PENDING;
				end else begin
					ring_wait[s] = ring_wait[s] - 8'd1;
					if (ring_wait[s] == 0) begin
						retag(s, SLOT_READY);
						r.became_ready = 1'b1;
					end
				end
			end
			OP_CONSUME: begin
				if (!head_live()) begin
					r.status = STS_NOT_READY;
				end else begin
					retag(rd_ptr, SLOT_FREE);
					ring_wait[rd_ptr]    = '0;
					ring_lanes[rd_ptr]   = '0;
					word_written[rd_ptr] = '0;
					rd_ptr = (rd_ptr + 1) % ring_size;
					fill--;
				end
			end
			OP_WRITE: begin
				if (!token_valid(it.token_slot, it.token_stamp)) begin
					r.status = STS_STALE;
				end else begin
					payload_mem[s*SLOT_WORDS + pos] = it.write_value;
					word_written[s][pos] = 1'b1;
					ever_stored[s][pos]  = 1'b1;
				end
			end
			OP_READ: begin
				if (!head_live()) r.status = STS_NOT_READY;
				else if (word_written[rd_ptr][pos])
					r.read_value = payload_mem[rd_ptr*SLOT_WORDS + pos];
			end
			default: begin
			end
		endcase
		r.head_is_ready = head_live();
		r.fill_level    = fill[SIZE_W-1:0];
		r.ready_total   = ready_cnt[SIZE_W-1:0];
		r.waiting_total = wait_cnt[SIZE_W-1:0];
		r.head_lanes    = (fill != 0) ? ring_lanes[rd_ptr] : '0;
	endtask

	// ------------------------------------------------------------------
	// Input side: one transaction per call, bursts with random gaps.
	// ------------------------------------------------------------------
	task automatic send_op(input item_t it);
		result_t r;
		// Insert a gap between bursts; valid drops here and in wait_drain, and is
		// raised again at a later edge.
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		in_valid       <= 1'b1;
		opcode         <= it.opcode;
		token_slot     <= it.token_slot;
		token_stamp    <= it.token_stamp;
		response_count <= it.response_count;
		lane_mask      <= it.lane_mask;
		lane           <= it.lane;
		word_index     <= it.word_index;
		write_value    <= it.write_value;
		// Hold the payload until the block takes it.
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_queue_op(it, r);
		awaited_results.push_back(r);
	endtask

	// Stop offering and wait until every result has drained.
	task automatic wait_drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Resize the ring; only done with the block idle. The write also
	// empties the ring but keeps the stamp sequence.
	task automatic set_size(input logic [SIZE_W-1:0] v);
		wait_drain();
		cfg_write_data <= v;
		cfg_write_en   <= 1'b1;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		ring_size = (v < 1) ? 1 : ((v > RING_MAX) ? RING_MAX : int'(v));
		clear_ring();
	endtask

	function automatic item_t mk(op_t op, int slot, logic [31:0] stamp);
		item_t it;
		it = '0;
		it.opcode      = op;
		it.token_slot  = slot[3:0];
		it.token_stamp = stamp;
		return it;
	endfunction

	function automatic int pick_slot(bit want_wait);
		int start;
		int s;
		start = $urandom_range(0, RING_MAX-1);
		for (int i = 0; i < RING_MAX; i++) begin
			s = (start + i) % RING_MAX;
			if (want_wait ? (ring_state[s] == SLOT_WAIT) : (ring_state[s] != SLOT_FREE))
				return s;
		end
		return -1;
	endfunction

	// Mostly well-formed operations on live entries with random content,
	// the rest stale tokens and plain noise.
	function automatic item_t rand_item();
		item_t      it;
		int         r;
		int         s;
		int         sw;
		int         start;
		int         p;
		bit         found;
		it.opcode         = op_t'($urandom_range(0, 7));
		it.token_slot     = SLOT_W'($urandom);
		it.token_stamp    = $urandom;
		it.response_count = COUNT_W'($urandom);
		it.lane_mask      = $urandom;
		it.lane           = LANE_W'($urandom);
		it.word_index     = WIDX_W'($urandom);
		it.write_value    = {$urandom, $urandom};
		r  = $urandom_range(0, 99);
		s  = pick_slot(1'b0);
		sw = pick_slot(1'b1);
		if (r < 10) begin
			// noise: keep the random fields
		end else if (r < 28) begin
			it.opcode = OP_RESERVE;
			if ($urandom_range(0, 7) != 0) it.response_count = COUNT_W'($urandom_range(0, 3));
		end else if (r < 52) begin
			it.opcode = OP_MARK;
			if (sw >= 0) s = sw;
		end else if (r < 58) begin
			it.opcode = OP_SET_PEND;
			if ($urandom_range(0, 7) != 0) it.response_count = COUNT_W'($urandom_range(0, 2));
		end else if (r < 66) begin
			it.opcode = OP_QUERY;
		end else if (r < 80) begin
			it.opcode = OP_WRITE;
		end else if (r < 89) begin
			it.opcode = OP_READ;
		end else if (r < 98) begin
			it.opcode = OP_CONSUME;
		end else begin
			it.opcode = OP_NOP;
		end
		// Use a good token most of the time; otherwise the stored stamp of a
		// random slot (live, freed or out of range) or a fully random token.
		if (r >= 10 && s >= 0 && $urandom_range(0, 7) != 0) begin
			it.token_slot  = s[3:0];
			it.token_stamp = ring_stamp[s];
		end else if ($urandom_range(0, 1)) begin
			it.token_stamp = ring_stamp[it.token_slot];
		end
		// Steer reads to payload words that have been stored at least once.
		if (it.opcode == OP_READ && !ever_stored[rd_ptr][{it.lane, it.word_index}]) begin
			found = 1'b0;
			start = $urandom_range(0, SLOT_WORDS-1);
			for (int i = 0; i < SLOT_WORDS && !found; i++) begin
				p = (start + i) % SLOT_WORDS;
				if (ever_stored[rd_ptr][p]) begin
					{it.lane, it.word_index} = p[5:0];
					found = 1'b1;
				end
			end
			if (!found) it.opcode = OP_NOP;
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Output side: the receiver stalls on its own pattern, and on request
	// holds off for a long counted stretch.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = hold_len;
		end
		if (rx_mode_left == 0) begin
			rx_mode      = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(20, 200);
		end else begin
			rx_mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (cycle_count % 5 != 0);
			endcase
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= 10)
				$display("mismatch on %s at cycle %0d: expected %h, got %h",
					name, cycle_count, want, got);
		end
	endtask

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result at cycle %0d with nothing awaited", cycle_count);
			end else begin
				want = awaited_results.pop_front();
				check_field("status",        64'(want.status),        64'(status));
				check_field("given_slot",    64'(want.given_slot),    64'(given_slot));
				check_field("given_stamp",   64'(want.given_stamp),   64'(given_stamp));
				check_field("became_ready",  64'(want.became_ready),  64'(became_ready));
				check_field("has_pending",   64'(want.has_pending),   64'(has_pending));
				check_field("read_value",    want.read_value,         read_value);
				check_field("head_is_ready", 64'(want.head_is_ready), 64'(head_is_ready));
				check_field("fill_level",    64'(want.fill_level),    64'(fill_level));
				check_field("ready_total",   64'(want.ready_total),   64'(ready_total));
				check_field("waiting_total", 64'(want.waiting_total), 64'(waiting_total));
				check_field("head_lanes",    64'(want.head_lanes),    64'(head_lanes));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Retire and mark on an empty ring, then a no-op with every field at
	// its top value.
	task automatic test_empty_ring();
		item_t it;
		send_op(mk(OP_CONSUME, 0, 32'd0));
		send_op(mk(OP_MARK, 0, 32'd0));
		it = mk(OP_NOP, 15, '1);
		it.response_count = '1;
		it.lane_mask      = '1;
		it.lane           = '1;
		it.word_index     = '1;
		it.write_value    = '1;
		send_op(it);
	endtask

	// Reserve a ready and a waiting entry, query both, and try bad tokens.
	task automatic test_reserve_and_query();
		item_t it;
		it = mk(OP_RESERVE, 0, 32'd0);
		it.lane_mask = '1;
		send_op(it);
		it = mk(OP_RESERVE, 0, 32'd0);
		it.response_count = '1;
		send_op(it);
		send_op(mk(OP_QUERY, 0, ring_stamp[0]));
		send_op(mk(OP_QUERY, 1, ring_stamp[1]));
		// mark with nothing pending
		send_op(mk(OP_MARK, 0, ring_stamp[0]));
		send_op(mk(OP_QUERY, 1, ~ring_stamp[1]));
		send_op(mk(OP_QUERY, 15, 32'd0));
	endtask

	// Store payload in the head and in the next entry, read the head back, and try a bad stamp.
	task automatic test_payload();
		item_t it;
		it = mk(OP_WRITE, 0, ring_stamp[0]);
		it.lane = '1;
		it.word_index = 1'b1;
		it.write_value = '1;
		send_op(it);
		it = mk(OP_WRITE, 0, ring_stamp[0]);
		it.write_value = 64'h0123_4567_89ab_cdef;
		send_op(it);
		it = mk(OP_WRITE, 1, ring_stamp[1]);
		it.lane = '1;
		it.word_index = 1'b1;
		it.write_value = 64'h5555_aaaa_5555_aaaa;
		send_op(it);
		it = mk(OP_READ, 0, 32'd0);
		it.lane = '1;
		it.word_index = 1'b1;
		send_op(it);
		send_op(mk(OP_READ, 0, 32'd0));
		it = mk(OP_WRITE, 1, ring_stamp[1] + 32'd7);
		it.write_value = '1;
		send_op(it);
	endtask

	// A ready head made waiting again blocks reads until its last response.
	task automatic test_pending_rules();
		item_t it;
		it = mk(OP_SET_PEND, 0, ring_stamp[0]);
		it.response_count = 8'd1;
		send_op(it);
		send_op(mk(OP_READ, 0, 32'd0));
		send_op(mk(OP_MARK, 0, ring_stamp[0]));
		send_op(mk(OP_SET_PEND, 1, ring_stamp[1]));
	endtask

	// Retire both entries; a token of a freed entry must be refused.
	task automatic test_retire_and_stale();
		item_t it;
		send_op(mk(OP_CONSUME, 0, 32'd0));
		send_op(mk(OP_QUERY, 0, ring_stamp[0]));
		it = mk(OP_READ, 0, 32'd0);
		it.lane = '1;
		it.word_index = 1'b1;
		send_op(it);
		send_op(mk(OP_CONSUME, 0, 32'd0));
		send_op(mk(OP_CONSUME, 0, 32'd0));
	endtask

	// One-entry ring: full reserve, slot beyond the size, payload written
	// before the entry was reserved reads as zero, read on an empty ring.
	task automatic test_full_ring();
		item_t it;
		set_size(5'd0);
		it = mk(OP_RESERVE, 0, 32'd0);
		it.response_count = 8'd1;
		it.lane_mask = 32'hdead_beef;
		send_op(it);
		send_op(mk(OP_RESERVE, 0, 32'd0));
		send_op(mk(OP_QUERY, 1, 32'd0));
		it = mk(OP_READ, 0, 32'd0);
		it.lane = '1;
		it.word_index = 1'b1;
		send_op(it);
		send_op(mk(OP_MARK, 0, ring_stamp[0]));
		send_op(it);
		send_op(mk(OP_CONSUME, 0, 32'd0));
		send_op(it);
		// The stamp wrap past all ones needs 2**32 reserves and is not run.
	endtask

	// Receiver holds off while the sender keeps offering, so the block
	// fills and stalls its input.
	task automatic test_backpressure();
		set_size(5'd16);
		gaps_on  = 1'b0;
		hold_len = 400;
		hold_req++;
		repeat (40) send_op(rand_item());
		wait_drain();
		gaps_on = 1'b1;
	endtask

	// Random traffic over a run of ring sizes, extremes and clamped values
	// among them; one phase pauses the sender midway until all results drain.
	task automatic test_random_phases();
		int sizes [10];
		int v;
		sizes = '{16, 1, 31, 3, 0, 8, 16, 2, 5, 31};
		for (int ph = 0; ph < 10; ph++) begin
			v = (ph == 5 || ph == 8) ? int'($urandom_range(0, 31)) : sizes[ph];
			set_size(v[SIZE_W-1:0]);
			gaps_on = ($urandom_range(0, 2) != 0);
			if (ph == 3) begin
				hold_len = 300;
				hold_req++;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 6 && n == PHASE_ITEMS / 2) wait_drain();
				send_op(rand_item());
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < RING_MAX; i++) ever_stored[i] = '0;
		clear_ring();
		ring_size  = RING_MAX;
		stamp_next = 32'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_reserve_and_query();
		test_payload();
		test_pending_rules();
		test_retire_and_stale();
		test_full_ring();
		test_backpressure();
		test_random_phases();

		wait_drain();
		repeat (20) @(posedge clk);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
